>>> rtl/core/s7d_pkg.sv
// Shared types, constants and segment functions for the seven-segment display block.
`timescale 1ns / 1ps
`default_nettype none
package s7d_pkg;

  // Number of display positions.
  localparam int DIGITS = 4;

  function automatic int pow10(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam int SHOW_HI = pow10(DIGITS) - 1;
  localparam int SHOW_LO = -(pow10(DIGITS - 1) - 1);
  localparam int MAG_W   = $clog2(SHOW_HI + 1);
  localparam int POS_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int EK_W    = $clog2(DIGITS + 2);

  // Divide by ten as a multiply by a rounded-up reciprocal; exact below 2**MAG_W.
  localparam int DIV_S = MAG_W + 4;
  localparam int DIV_K = (2 ** DIV_S + 9) / 10;
  localparam int PROD_W = MAG_W + DIV_S - 3;

  // Command queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_SHOW    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;
  localparam logic [1:0] CMD_BRIGHT  = 2'd3;

  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_H     = 8'h76;
  localparam logic [7:0] SEG_L     = 8'h38;

  localparam logic [7:0] BYTE_DATA_MODE = 8'h40;
  localparam logic [7:0] BYTE_ADDR_0    = 8'hC0;
  localparam logic [7:0] BYTE_DISP_OFF  = 8'h80;
  localparam logic [7:0] BYTE_DISP_MAX  = 8'h8F;
  localparam logic [7:0] BYTE_DISP_BASE = 8'h88;
  localparam logic [7:0] BRIGHT_RESET   = 8'd100;
  localparam logic [7:0] BRIGHT_MIN     = 8'd5;
  localparam logic [7:0] BRIGHT_FULL    = 8'd100;
  // Divide by twelve for values below 95: (x * 171) >> 11.
  localparam logic [7:0] BRIGHT_RECIP   = 8'd171;
  localparam int         BRIGHT_SHIFT   = 11;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
    logic [2:0]         position;
    logic [7:0]         character;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       starts_transfer;
    logic       ends_transfer;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_SHOW,
    OP_FILL,
    OP_SET,
    OP_REFRESH,
    OP_BRIGHT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       seg;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [POS_W-1:0] pos;
  } work_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/s7d_front.sv
// Front part: accepts items, classifies them and pushes work into the queue.
`timescale 1ns / 1ps
`default_nettype none
module s7d_front (
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire s7d_pkg::in_item_t in_item,
  input  wire logic             q_full,
  output logic                  push,
  output s7d_pkg::work_t        push_item
);
  import s7d_pkg::*;

  localparam logic signed [31:0] HI_S = 32'(SHOW_HI);
  localparam logic signed [31:0] LO_S = 32'(SHOW_LO);

  logic        accept;
  logic        drop;
  logic [31:0] abs_val;
  logic [7:0]  char_seg;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A set to a position past the display changes nothing and emits nothing.
  assign drop = (in_item.command == CMD_SET) &&
                (32'(in_item.position) >= 32'(DIGITS));
  assign push = accept && !drop;

  assign abs_val = in_item.value[31] ? (32'd0 - in_item.value) : in_item.value;

  always_comb begin
    if (in_item.character >= "0" && in_item.character <= "9") begin
      char_seg = seg_digit(in_item.character[3:0]);
    end else if (in_item.character == "-") begin
      char_seg = SEG_MINUS;
    end else begin
      char_seg = SEG_BLANK;
    end
  end

  always_comb begin
    push_item.op  = OP_REFRESH;
    push_item.seg = SEG_BLANK;
    push_item.mag = abs_val[MAG_W-1:0];
    push_item.neg = in_item.value[31];
    push_item.pos = in_item.position[POS_W-1:0];
    unique case (in_item.command)
      CMD_SHOW: begin
        if (in_item.value > HI_S) begin
          push_item.op  = OP_FILL;
          push_item.seg = SEG_H;
        end else if (in_item.value < LO_S) begin
          push_item.op  = OP_FILL;
          push_item.seg = SEG_L;
        end else begin
          push_item.op = OP_SHOW;
        end
      end
      CMD_SET: begin
        push_item.op  = OP_SET;
        push_item.seg = char_seg;
      end
      CMD_REFRESH: push_item.op = OP_REFRESH;
      CMD_BRIGHT:  push_item.op = OP_BRIGHT;
      default:     push_item.op = OP_REFRESH;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/s7d_queue.sv
// Short work queue that lets the front and back parts stall independently.
`timescale 1ns / 1ps
`default_nettype none
module s7d_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire s7d_pkg::work_t push_item,
  output logic                full,
  output logic                q_valid,
  output s7d_pkg::work_t      q_item,
  input  wire logic           pop
);
  import s7d_pkg::*;

  work_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/s7d_back.sv
// Back part: display memory, digit conversion sequencer and output byte register.
`timescale 1ns / 1ps
`default_nettype none
module s7d_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  input  wire logic            q_valid,
  input  wire s7d_pkg::work_t  q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output s7d_pkg::out_item_t   out_item
);
  import s7d_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  localparam logic [PROD_W-1:0] DIV_K_V = PROD_W'(DIV_K);

  state_t            state;
  logic [7:0]        mem [DIGITS];
  logic [7:0]        bright;
  logic [MAG_W-1:0]  m;
  logic              neg;
  logic              first;
  logic [POS_W-1:0]  pos;
  logic [EK_W-1:0]   k;
  logic              bsel;

  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  q;
  logic [MAG_W-1:0]  rem;
  logic [7:0]        conv_seg;
  logic [POS_W-1:0]  rd_idx;
  logic [6:0]        br_x;
  logic [14:0]       br_prod;
  logic [7:0]        bright_byte;
  logic              out_free;
  logic              emit_fire;
  logic              emit_end;
  out_item_t         emit_item;

  assign pop       = (state == ST_IDLE) && q_valid;
  assign out_free  = !out_valid || out_ready;
  assign emit_fire = (state == ST_EMIT) && out_free;

  // One decimal digit per cycle: quotient by reciprocal, remainder by shift-add.
  assign prod = PROD_W'(m) * DIV_K_V;
  assign q    = MAG_W'(prod >> DIV_S);
  assign rem  = m - ((q << 3) + (q << 1));

  always_comb begin
    if (first || m != '0) begin
      conv_seg = seg_digit(rem[3:0]);
    end else if (neg) begin
      conv_seg = SEG_MINUS;
    end else begin
      conv_seg = SEG_BLANK;
    end
  end

  assign br_x    = 7'(bright - BRIGHT_MIN);
  assign br_prod = 15'(br_x) * 15'(BRIGHT_RECIP);

  always_comb begin
    if (bright < BRIGHT_MIN) begin
      bright_byte = BYTE_DISP_OFF;
    end else if (bright >= BRIGHT_FULL) begin
      bright_byte = BYTE_DISP_MAX;
    end else begin
      bright_byte = BYTE_DISP_BASE | 8'(br_prod >> BRIGHT_SHIFT);
    end
  end

  assign rd_idx   = POS_W'(k - EK_W'(2));
  assign emit_end = bsel || (k == EK_W'(DIGITS + 1));

  always_comb begin
    if (bsel) begin
      emit_item = '{out_byte: bright_byte, starts_transfer: 1'b1,
                    ends_transfer: 1'b1, last: 1'b1};
    end else if (k == EK_W'(0)) begin
      emit_item = '{out_byte: BYTE_DATA_MODE, starts_transfer: 1'b1,
                    ends_transfer: 1'b1, last: 1'b0};
    end else if (k == EK_W'(1)) begin
      emit_item = '{out_byte: BYTE_ADDR_0, starts_transfer: 1'b1,
                    ends_transfer: 1'b0, last: 1'b0};
    end else begin
      emit_item = '{out_byte: mem[rd_idx], starts_transfer: 1'b0,
                    ends_transfer: emit_end, last: emit_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      bright    <= BRIGHT_RESET;
      for (int i = 0; i < DIGITS; i++) begin
        mem[i] <= SEG_BLANK;
      end
    end else begin
      if (cfg_wr_en) begin
        bright <= cfg_wr_data;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            k    <= '0;
            bsel <= (q_item.op == OP_BRIGHT);
            unique case (q_item.op)
              OP_SHOW: begin
                m     <= q_item.mag;
                neg   <= q_item.neg;
                first <= 1'b1;
                pos   <= POS_W'(DIGITS - 1);
                state <= ST_CONV;
              end
              OP_FILL: begin
                for (int i = 0; i < DIGITS; i++) begin
                  mem[i] <= q_item.seg;
                end
                state <= ST_EMIT;
              end
              OP_SET: begin
                mem[q_item.pos] <= q_item.seg;
              end
              OP_REFRESH: state <= ST_EMIT;
              OP_BRIGHT: begin
                state <= ST_EMIT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CONV: begin
          mem[pos] <= conv_seg;
          first    <= 1'b0;
          if (first || m != '0) begin
            m <= q;
          end else if (neg) begin
            neg <= 1'b0;
          end
          if (pos == '0) begin
            state <= ST_EMIT;
          end else begin
            pos <= pos - 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_item <= emit_item;
            if (emit_end) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/int_to_seven_segment_display_top.sv
// Top level of the seven-segment display byte generator.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_ready   in_item (command, value, position, character)
//   out       output     out_valid / out_ready out_item (byte, start, stop, last)
//   cfg       input      cfg_wr_en             cfg_wr_data (brightness percent)
//
// A show item converts one digit per cycle through the divide-by-ten multiplier and then
// emits DIGITS + 2 bytes; a refresh emits the same DIGITS + 2 bytes, a brightness item
// one byte and a set item none.
// The output register moves one byte per cycle; a low out_ready holds the back part,
// while the front keeps taking items until the two-entry queue fills.
// Synchronous reset blanks the display memory and sets brightness to 100.
`timescale 1ns / 1ps
`default_nettype none
module int_to_seven_segment_display_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire s7d_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output s7d_pkg::out_item_t      out_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data
);
  import s7d_pkg::*;

  logic  push;
  work_t push_item;
  logic  q_full;
  logic  q_valid;
  work_t q_item;
  logic  pop;

  s7d_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  s7d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  s7d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/core/s7d_checker.sv
// Port-level checker for the seven-segment display block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module s7d_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire s7d_pkg::out_item_t out_item
);
  import s7d_pkg::*;

  // A stalled output item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // Reset leaves no output item pending and the front ready.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // The final byte of an item always closes a transfer.
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last |-> out_item.ends_transfer)
    else $error("last byte without stop");

  // A lone single-byte transfer that is not last is the data-mode command.
  a_mode_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.starts_transfer && out_item.ends_transfer && !out_item.last
    |-> out_item.out_byte == BYTE_DATA_MODE)
    else $error("unexpected single-byte transfer");

  // The address command always follows the data-mode command directly.
  a_addr_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.starts_transfer && out_item.ends_transfer &&
    !out_item.last |=> out_valid && out_item.out_byte == BYTE_ADDR_0 &&
    out_item.starts_transfer && !out_item.ends_transfer)
    else $error("address command missing after data-mode command");

endmodule

bind int_to_seven_segment_display_top s7d_checker u_s7d_checker (.*);
`default_nettype wire

>>> test/int_to_seven_segment_display_top_tb.sv
// Self-checking testbench for the seven-segment display byte generator.
`timescale 1ns / 1ps
module int_to_seven_segment_display_top_tb;
  import s7d_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_GAP      = 13;
  localparam int SETTLE       = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 78;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_wr_en;
  logic [7:0] cfg_wr_data;

  // Scoreboard and shadow copy of the display state.
  out_item_t  expected_bytes[$];
  logic [7:0] display_image[DIGITS];
  logic [7:0] brightness_pct;
  logic [7:0] digit_pattern[10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                   8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
  int error_count = 0;
  int stuck_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;

  int_to_seven_segment_display_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  task automatic queue_byte(input logic [7:0] b, input logic st, input logic en,
                            input logic lst);
    out_item_t r;
    r.out_byte        = b;
    r.starts_transfer = st;
    r.ends_transfer   = en;
    r.last            = lst;
    expected_bytes.push_back(r);
  endtask

  task automatic queue_refresh();
    queue_byte(BYTE_DATA_MODE, 1'b1, 1'b1, 1'b0);
    queue_byte(BYTE_ADDR_0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < DIGITS; i++) begin
      queue_byte(display_image[i], 1'b0, i == DIGITS - 1, i == DIGITS - 1);
    end
  endtask

  task automatic render_value(input longint v);
    longint top_val;
    longint bottom_val;
    longint mag;
    bit neg;
    top_val = 1;
    for (int i = 0; i < DIGITS; i++) begin
      top_val = top_val * 10;
    end
    bottom_val = -(top_val / 10 - 1);
    top_val = top_val - 1;
    if (v > top_val) begin
      for (int i = 0; i < DIGITS; i++) display_image[i] = SEG_H;
    end else if (v < bottom_val) begin
      for (int i = 0; i < DIGITS; i++) display_image[i] = SEG_L;
    end else begin
      neg = v < 0;
      mag = neg ? -v : v;
      display_image[DIGITS - 1] = digit_pattern[mag % 10];
      for (int i = DIGITS - 2; i >= 0; i--) begin
        if (mag >= 10) begin
          mag = mag / 10;
          display_image[i] = digit_pattern[mag % 10];
        end else if (neg) begin
          neg = 1'b0;
          display_image[i] = SEG_MINUS;
        end else begin
          display_image[i] = SEG_BLANK;
        end
      end
    end
  endtask

  // Works out the bytes one accepted item must produce and updates the shadow state.
  task automatic predict_display_bytes(input in_item_t it);
    logic [7:0] level;
    case (it.command)
      CMD_SHOW: begin
        render_value(longint'(it.value));
        queue_refresh();
      end
      CMD_SET: begin
        if (it.position < DIGITS) begin
          if (it.character >= "0" && it.character <= "9")
            display_image[it.position] = digit_pattern[it.character - "0"];
          else if (it.character == "-")
            display_image[it.position] = SEG_MINUS;
          else
            display_image[it.position] = SEG_BLANK;
        end
      end
      CMD_REFRESH: begin
        queue_refresh();
      end
      default: begin
        if (brightness_pct < BRIGHT_MIN)
          level = BYTE_DISP_OFF;
        else if (brightness_pct >= BRIGHT_FULL)
          level = BYTE_DISP_MAX;
        else
          level = BYTE_DISP_BASE | 8'((brightness_pct - BRIGHT_MIN) / 12);
        queue_byte(level, 1'b1, 1'b1, 1'b1);
      end
    endcase
  endtask

  // Entered and left in the time step of a rising edge; valid stays high after
  // acceptance until the next call decides whether to drop it.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_display_bytes(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // A trailing set item leaves no byte behind, so give the block time to finish it.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [7:0] pct);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pct;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    brightness_pct = pct;
  endtask

  function automatic in_item_t make_random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) it.command = CMD_SHOW;
    else if (pick < 14) it.command = CMD_SET;
    else if (pick < 17) it.command = CMD_REFRESH;
    else it.command = CMD_BRIGHT;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      it.value = int'($urandom_range(0, 13000)) - 1500;
    end else if (pick == 6) begin
      case ($urandom_range(0, 5))
        0: it.value = 9999;
        1: it.value = 10000;
        2: it.value = -999;
        3: it.value = -1000;
        4: it.value = 0;
        default: it.value = -9;
      endcase
    end else begin
      it.value = $urandom;
    end
    if ($urandom_range(0, 4) == 0) it.position = 3'($urandom_range(0, 7));
    else it.position = 3'($urandom_range(0, DIGITS - 1));
    pick = $urandom_range(0, 14);
    if (pick > 10) it.character = 8'($urandom);
    else if (pick == 10) it.character = "-";
    else it.character = 8'("0" + pick);
    return it;
  endfunction

  task automatic send_show(input int v);
    in_item_t it;
    it = make_random_item();
    it.command = CMD_SHOW;
    it.value = v;
    send_item(it);
  endtask

  task automatic send_set(input logic [2:0] pos, input logic [7:0] ch);
    in_item_t it;
    it = make_random_item();
    it.command = CMD_SET;
    it.position = pos;
    it.character = ch;
    send_item(it);
  endtask

  task automatic send_plain(input logic [1:0] cmd);
    in_item_t it;
    it = make_random_item();
    it.command = cmd;
    send_item(it);
  endtask

  task automatic test_reset_state();
    send_plain(CMD_REFRESH);
    send_plain(CMD_BRIGHT);
  endtask

  task automatic test_show_values();
    send_show(0);
    send_show(7);
    send_show(-1);
    send_show(-42);
    send_show(-999);
    send_show(-1000);
    send_show(9999);
    send_show(10000);
    send_show(32'sh7FFF_FFFF);
    send_show(32'sh8000_0000);
  endtask

  task automatic test_set_symbols();
    send_set(3'd0, "-");
    send_set(3'd1, "9");
    send_set(3'd2, "A");
    send_set(3'd3, "0");
    send_set(3'd7, "5");
    send_plain(CMD_REFRESH);
  endtask

  task automatic test_brightness_levels();
    logic [7:0] levels[5] = '{8'd0, 8'd4, 8'd5, 8'd99, 8'd255};
    foreach (levels[i]) begin
      write_brightness(levels[i]);
      send_plain(CMD_BRIGHT);
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // internal queue fills and the input side has to stall.
  task automatic test_output_backpressure();
    in_item_t it;
    hold_off_req = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 16; i++) begin
      it = make_random_item();
      if (it.command == CMD_SET) it.command = CMD_SHOW;
      send_item(it);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      write_brightness(8'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_item(make_random_item());
      end
      no_gaps = 1'b0;
    end
  endtask

  // Receiver: a fresh stall before every item it takes.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: item expected none got %h", $time, out_item);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h got %h", $time, want.out_byte,
                   out_item.out_byte);
          error_count++;
        end
        if (out_item.starts_transfer !== want.starts_transfer) begin
          $display("%0t: starts_transfer expected %b got %b", $time,
                   want.starts_transfer, out_item.starts_transfer);
          error_count++;
        end
        if (out_item.ends_transfer !== want.ends_transfer) begin
          $display("%0t: ends_transfer expected %b got %b", $time,
                   want.ends_transfer, out_item.ends_transfer);
          error_count++;
        end
        if (out_item.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d bytes outstanding", $time,
                 stuck_cycles, expected_bytes.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    for (int i = 0; i < DIGITS; i++) display_image[i] = SEG_BLANK;
    brightness_pct = BRIGHT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_show_values();
    test_set_symbols();
    test_brightness_levels();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> int_to_seven_segment_display_top.f
rtl/core/s7d_pkg.sv
rtl/core/s7d_front.sv
rtl/core/s7d_queue.sv
rtl/core/s7d_back.sv
rtl/core/int_to_seven_segment_display_top.sv
rtl/core/s7d_checker.sv
test/int_to_seven_segment_display_top_tb.sv
